>>> hw/rtl/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared widths, register codes, the queued point type and saturation helper
// for the escape-time pixel block.
// ----------------------------------------------------------------------------
package mbe_pkg;

   localparam int unsigned ITER_LIMIT_DEF = 1024;
   localparam int unsigned IMAGE_DIM_DEF  = 1024;

   localparam int unsigned COL_W       = 10;
   localparam int unsigned IDX_W       = 13;
   localparam int unsigned Q_W         = 32;
   localparam int unsigned STEP_W      = 31;
   localparam int unsigned PROD_W      = COL_W + STEP_W;
   localparam int unsigned WIDE_W      = 48;
   localparam int unsigned SQ_W        = 64;
   localparam int unsigned UPD_W       = 40;
   localparam int unsigned Q_FRAC      = 28;
   localparam int unsigned ITER_W      = 10;
   localparam int unsigned COLOR_W     = 8;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned REQ_DATA_W  = 24;
   localparam int unsigned RSP_DATA_W  = 56;
   localparam int unsigned QUEUE_DEPTH = 4;

   // 4.0 in the Q8.56 format of the squared magnitude
   localparam logic [SQ_W-1:0] ESCAPE_Q56 = 64'h0400_0000_0000_0000;

   localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

   localparam logic signed [Q_W-1:0] ORIGIN_RE_RST = -32'sd402653184;
   localparam logic signed [Q_W-1:0] ORIGIN_IM_RST = -32'sd268435456;
   localparam logic [STEP_W-1:0]     STEP_RE_RST   = 31'd764773;
   localparam logic [STEP_W-1:0]     STEP_IM_RST   = 31'd764773;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_RE = 2'd0,
      CSR_ORIGIN_IM = 2'd1,
      CSR_STEP_RE   = 2'd2,
      CSR_STEP_IM   = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic                  valid;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_write_type;

   typedef struct packed {
      logic [COL_W-1:0]        col;
      logic [COL_W-1:0]        row;
      logic signed [Q_W-1:0]   c_re;
      logic signed [Q_W-1:0]   c_im;
   } point_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_MUL,
      ENG_TEST,
      ENG_DONE
   } eng_state_type;

   // clip a wide signed value to the Q4.28 range
   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
      logic signed [Q_W-1:0] r;
      if (v[WIDE_W-1:Q_W-1] == {(WIDE_W-Q_W+1){v[WIDE_W-1]}}) begin
         r = v[Q_W-1:0];
      end else if (v[WIDE_W-1]) begin
         r = Q_MIN;
      end else begin
         r = Q_MAX;
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/mbe_front.sv
// ----------------------------------------------------------------------------
// mbe_front
// Holds the coordinate registers, takes pixel items, clamps the indices and
// maps each pixel to its point c, then hands it to the queue.
// ----------------------------------------------------------------------------
module mbe_front #(
   parameter int unsigned IMAGE_DIM = mbe_pkg::IMAGE_DIM_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mbe_pkg::csr_write_type        csr_wr,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [mbe_pkg::COL_W-1:0]     in_col,
   input  logic [mbe_pkg::COL_W-1:0]     in_row,
   output logic                          push_valid,
   input  logic                          push_ready,
   output mbe_pkg::point_type            push_item
);
   import mbe_pkg::*;

   logic signed [Q_W-1:0] origin_re_ff, origin_im_ff;
   logic [STEP_W-1:0]     step_re_ff, step_im_ff;

   logic                  s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0]      col_ff, row_ff;
   logic [PROD_W-1:0]     prod_re_ff, prod_re_in;
   logic [PROD_W-1:0]     prod_im_ff, prod_im_in;
   logic [COL_W-1:0]      ci, ri;
   logic signed [WIDE_W-1:0] sum_re, sum_im;
   logic                  take;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_re_ff <= ORIGIN_RE_RST;
         origin_im_ff <= ORIGIN_IM_RST;
         step_re_ff   <= STEP_RE_RST;
         step_im_ff   <= STEP_IM_RST;
      end else if (csr_wr.valid) begin
         unique case (csr_reg_type'(csr_wr.index))
            CSR_ORIGIN_RE: origin_re_ff <= csr_wr.data;
            CSR_ORIGIN_IM: origin_im_ff <= csr_wr.data;
            CSR_STEP_RE:   step_re_ff   <= csr_wr.data[STEP_W-1:0];
            CSR_STEP_IM:   step_im_ff   <= csr_wr.data[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // indices past the image edge use the last pixel
   always_comb begin
      ci = in_col;
      ri = in_row;
      if (IDX_W'(in_col) >= IDX_W'(IMAGE_DIM)) begin
         ci = COL_W'(IMAGE_DIM - 1);
      end
      if (IDX_W'(in_row) >= IDX_W'(IMAGE_DIM)) begin
         ri = COL_W'(IMAGE_DIM - 1);
      end
      prod_re_in = PROD_W'(ci) * PROD_W'(step_re_ff);
      prod_im_in = PROD_W'(ri) * PROD_W'(step_im_ff);
   end

   assign in_ready    = !s1_valid_ff || push_ready;
   assign take        = in_valid && in_ready;
   assign s1_valid_in = take || (s1_valid_ff && !push_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         col_ff     <= in_col;
         row_ff     <= in_row;
         prod_re_ff <= prod_re_in;
         prod_im_ff <= prod_im_in;
      end
   end

   always_comb begin
      sum_re = WIDE_W'(origin_re_ff) + $signed(WIDE_W'(prod_re_ff));
      sum_im = WIDE_W'(origin_im_ff) + $signed(WIDE_W'(prod_im_ff));
      push_item.col  = col_ff;
      push_item.row  = row_ff;
      push_item.c_re = sat_q(sum_re);
      push_item.c_im = sat_q(sum_im);
   end

   assign push_valid = s1_valid_ff;

endmodule

>>> hw/rtl/mbe_queue.sv
// ----------------------------------------------------------------------------
// mbe_queue
// Short first-in first-out queue of mapped points between the front and the
// iteration engine.
// ----------------------------------------------------------------------------
module mbe_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  mbe_pkg::point_type   push_item,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output mbe_pkg::point_type   pop_item
);
   import mbe_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   point_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               push, pop;

   assign push_ready = (cnt_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

   a_cnt_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count missed a push");

   a_cnt_down: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> cnt_ff == $past(cnt_ff) - 1'b1)
      else $error("queue count missed a pop");
`endif

endmodule

>>> hw/rtl/mbe_engine.sv
// ----------------------------------------------------------------------------
// mbe_engine
// Iterates z = z*z + c for one queued point at a time, square then test,
// and holds the finished count and palette in the result register.
// ----------------------------------------------------------------------------
module mbe_engine #(
   parameter int unsigned ITER_LIMIT = mbe_pkg::ITER_LIMIT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  mbe_pkg::point_type            pop_item,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mbe_pkg::RSP_DATA_W-1:0] rsp_data
);
   import mbe_pkg::*;

   localparam int unsigned CNT_W =
      ($clog2(ITER_LIMIT + 2) > ITER_W) ? $clog2(ITER_LIMIT + 2) : ITER_W;

   eng_state_type          state_ff, state_in;
   point_type              pt_ff;
   logic signed [Q_W-1:0]  zr_ff, zi_ff;
   logic signed [SQ_W-1:0] rr_ff, ii_ff, ri_ff;
   logic signed [SQ_W-1:0] rr_in, ii_in, ri_in;
   logic [CNT_W-1:0]       count_ff;
   logic [SQ_W-1:0]        mag;
   logic                   stop;
   logic signed [SQ_W-1:0] diff, diff_sh, ri_sh;
   logic signed [UPD_W-1:0] nr, ni;
   logic signed [Q_W-1:0]  zr_next, zi_next;
   logic                   load_out;
   logic [CNT_W-1:0]       res;
   logic [COLOR_W-1:0]     red, green, blue;
   logic                   rsp_valid_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff;

   always_comb begin
      rr_in = zr_ff * zr_ff;
      ii_in = zi_ff * zi_ff;
      ri_in = zr_ff * zi_ff;
   end

   always_comb begin
      mag     = $unsigned(rr_ff) + $unsigned(ii_ff);
      stop    = (mag >= ESCAPE_Q56) || (count_ff > CNT_W'(ITER_LIMIT));
      diff    = rr_ff - ii_ff;
      diff_sh = diff >>> Q_FRAC;
      ri_sh   = ri_ff >>> (Q_FRAC - 1);
      nr      = $signed(diff_sh[UPD_W-1:0]) + UPD_W'(pt_ff.c_re);
      ni      = $signed(ri_sh[UPD_W-1:0]) + UPD_W'(pt_ff.c_im);
      zr_next = sat_q(WIDE_W'(nr));
      zi_next = sat_q(WIDE_W'(ni));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ENG_IDLE: if (pop_valid) state_in = ENG_MUL;
         ENG_MUL:  state_in = ENG_TEST;
         ENG_TEST: state_in = stop ? ENG_DONE : ENG_MUL;
         ENG_DONE: if (!rsp_valid_ff || rsp_ready) state_in = ENG_IDLE;
         default:  state_in = ENG_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop_ready = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         ENG_IDLE: pop_ready = 1'b1;
         ENG_DONE: load_out  = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ENG_IDLE && pop_valid) begin
         pt_ff    <= pop_item;
         zr_ff    <= pop_item.c_re;
         zi_ff    <= pop_item.c_im;
         count_ff <= CNT_W'(1);
      end else if (state_ff == ENG_TEST && !stop) begin
         zr_ff    <= zr_next;
         zi_ff    <= zi_next;
         count_ff <= count_ff + 1'b1;
      end
      if (state_ff == ENG_MUL) begin
         rr_ff <= rr_in;
         ii_ff <= ii_in;
         ri_ff <= ri_in;
      end
   end

   always_comb begin
      res   = (count_ff < CNT_W'(ITER_LIMIT)) ? count_ff : '0;
      green = res[COLOR_W-1:0];
      red   = COLOR_W'(0) - res[COLOR_W-1:0];
      blue  = red + green;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= {2'b00, blue, green, red, res[ITER_W-1:0], pt_ff.row, pt_ff.col};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_mul_then_test: assert property (@(posedge clock) disable iff (reset)
      state_ff == ENG_MUL |=> state_ff == ENG_TEST)
      else $error("square step not followed by escape test");

   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ENG_DONE)
      else $error("result register loaded outside the finish state");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ENG_TEST |-> count_ff != '0 && count_ff <= CNT_W'(ITER_LIMIT + 1))
      else $error("iteration count out of range");
`endif

endmodule

>>> hw/rtl/mandelbrot_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time pixel engine: maps a pixel to a point in Q4.28 and counts
// iterations of z = z*z + c until it leaves radius 2 or hits ITER_LIMIT.
// ----------------------------------------------------------------------------
// Usage
//   req_*  : one item per pixel, column in the low bits of tdata, row above.
//   rsp_*  : one item per pixel, in request order, carrying the echoed
//            column and row, the escape count and the palette colours.
//   csr_*  : register writes (origin re/im, step re/im), always ready; write
//            only while no pixel is in flight.
// Flow
//   The front maps a pixel, registers it and queues it (four entries). The
//   engine takes one pixel at a time; each iteration is a square step (the
//   three 32x32 products) followed by an escape test and update step. The
//   iteration loop sets the throughput.
// Reset clears the queue, the engine and the result valid, and reloads the
// registers to the default view. A stalled receiver holds the result; the
// engine runs one more pixel, waits in its finish state; the queue fills.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel #(
   parameter int unsigned ITER_LIMIT = mbe_pkg::ITER_LIMIT_DEF,
   parameter int unsigned IMAGE_DIM  = mbe_pkg::IMAGE_DIM_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pixel_col[9:0], pixel_row[19:10], zero pad
   input  logic [mbe_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_col[9:0], out_row[19:10], iterations[29:20], red[37:30],
   // green[45:38], blue[53:46], zero pad
   output logic [mbe_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mbe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mbe_pkg::CSR_DATA_W-1:0]    csr_data
);
   import mbe_pkg::*;

   csr_write_type csr_wr;
   logic          push_valid, push_ready;
   point_type     push_item;
   logic          pop_valid, pop_ready;
   point_type     pop_item;

   assign csr_ready    = 1'b1;
   assign csr_wr.valid = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   mbe_front #(
      .IMAGE_DIM (IMAGE_DIM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr     (csr_wr),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_col     (req_tdata[COL_W-1:0]),
      .in_row     (req_tdata[2*COL_W-1:COL_W]),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   mbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   mbe_engine #(
      .ITER_LIMIT (ITER_LIMIT)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata)
   );

endmodule
